// ----- sv/pia_pkg.sv -----
// ----------------------------------------------------------------------------
// pia_pkg
// Shared constants, types and helpers for the positional insert/delete list.
// ----------------------------------------------------------------------------
package pia_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int COUNT_W  = 7;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_LIST   = 2'd0;
    localparam t_cmd CMD_INSERT = 2'd1;
    localparam t_cmd CMD_DELETE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef struct packed {
        t_status                   status;
        logic signed [VAL_W-1:0]   value_res;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } t_res;

    typedef struct packed {
        logic valid;
        t_res res;
    } t_out_load;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [VAL_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } t_ctrl_stat;

    // Low bits of the entry count as carried on the result channel.
    function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
        logic [CMP_W-1:0] w;
        w = CMP_W'(c);
        return w[COUNT_W-1:0];
    endfunction

endpackage

// ----- sv/pia_in_if.sv -----
// ----------------------------------------------------------------------------
// pia_in_if
// Command channel: valid/ready handshake with command, position and value.
// ----------------------------------------------------------------------------
interface pia_in_if;
    import pia_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

// ----- sv/pia_out_if.sv -----
// ----------------------------------------------------------------------------
// pia_out_if
// Result channel: valid/ready handshake with status, value, count and last.
// ----------------------------------------------------------------------------
interface pia_out_if;
    import pia_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] value_res;
    logic [COUNT_W-1:0]      count;
    logic                    last;

    modport source (output valid, output status, output value_res, output count,
                    output last, input ready);
    modport sink   (input valid, input status, input value_res, input count,
                    input last, output ready);
endinterface

// ----- sv/positional_array_insert_delete.sv -----
// ----------------------------------------------------------------------------
// positional_array_insert_delete
// Bounded ordered list with 1-based positional insert, delete and listing.
// ----------------------------------------------------------------------------
// The list keeps up to CAPACITY (64) signed 32-bit entries in one RAM with a
// single write port and a registered read port, and works on one command item
// at a time; i_in.ready is high only while the sequencer is idle. A refused
// command (full, empty, bad position) goes straight to its result. Insert at
// position p into a list of n entries moves the n-p+1 entries from p on up by
// one, tail first, then writes the value; delete reads the removed entry and
// moves the n-p entries after it down by one. Each shift step is one read-back
// and one write through the RAM, so the single write port sets the pace. List
// emits one result per cycle while the output register has room; it holds its
// read while the output register is full. Results leave through an output
// register, so the next command item is taken while the last result still
// waits for the sink. Command code 3 is dropped and gives no result. The RAM
// needs no clearing after reset: only positions below the count are ever read.
// ----------------------------------------------------------------------------
module positional_array_insert_delete (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pia_in_if.sink     i_in,
    pia_out_if.source  o_out
);
    import pia_pkg::*;

    t_ram_req          ram_req;
    t_out_load         out_load;
    t_ctrl_stat        ctrl_stat;
    logic              out_free;
    logic [VAL_W-1:0]  rd_data;

    // Sequencer: check, shift and stream through the entry RAM.
    pia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_out_free (out_free),
        .i_rd_data  (rd_data),
        .o_ram      (ram_req),
        .o_load     (out_load),
        .o_stat     (ctrl_stat)
    );

    // Entry store: contents undefined until written.
    pia_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_en   (ram_req.rd_en),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_data)
    );

    // Hold each result until the sink takes it.
    pia_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    // Count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_stat.count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A full refusal reports a full count.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_FULL |-> o_out.count == count_field(CNT_W'(CAPACITY)))
        else $error("full status with count below capacity");

    // An empty status is always a single final result with count zero.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_EMPTY |-> o_out.last && o_out.count == '0)
        else $error("empty status not final or count nonzero");

    // Input is taken only when the sequencer is idle.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !ctrl_stat.busy)
        else $error("input ready while sequencer busy");
endmodule

// ----- sv/pia_ram.sv -----
// ----------------------------------------------------------------------------
// pia_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- sv/pia_out_reg.sv -----
// ----------------------------------------------------------------------------
// pia_out_reg
// Output register for the result channel; frees itself as the sink takes it.
// ----------------------------------------------------------------------------
module pia_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pia_pkg::t_out_load  i_load,
    output logic                o_free,
    pia_out_if.source           o_out
);
    import pia_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load.valid;
        end
        if (o_free && i_load.valid) begin
            r_res <= i_load.res;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.status    = r_res.status;
    assign o_out.value_res = r_res.value_res;
    assign o_out.count     = r_res.count;
    assign o_out.last      = r_res.last;
endmodule

// ----- sv/pia_ctrl.sv -----
// ----------------------------------------------------------------------------
// pia_ctrl
// Command sequencer: checks commands, runs the shift loops through the RAM
// and streams list results.
// ----------------------------------------------------------------------------
module pia_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pia_in_if.sink               i_in,
    input  logic                 i_out_free,
    input  logic [pia_pkg::VAL_W-1:0] i_rd_data,
    output pia_pkg::t_ram_req    o_ram,
    output pia_pkg::t_out_load   o_load,
    output pia_pkg::t_ctrl_stat  o_stat
);
    import pia_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIST,
        S_INS_SHIFT,
        S_INS_WR,
        S_DEL_RM,
        S_DEL_SHIFT,
        S_RESP
    } t_state;

    t_state                  r_state,  n_state;
    logic [CNT_W-1:0]        r_count,  n_count;
    logic [ADDR_W-1:0]       r_idx,    n_idx;
    logic [ADDR_W-1:0]       r_pos_a,  n_pos_a;
    logic [VAL_W-1:0]        r_val,    n_val;
    t_status                 r_status, n_status;
    logic [VAL_W-1:0]        r_res,    n_res;

    logic             accept;
    logic [CMP_W-1:0] in_pos_w;
    logic [CMP_W-1:0] pos_m1_w;
    logic [CMP_W-1:0] cnt_w;
    logic [CMP_W-1:0] idx_w;
    logic [CMP_W-1:0] pos_a_w;
    logic             is_full;
    logic             is_empty;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign in_pos_w   = CMP_W'(i_in.position);
    assign pos_m1_w   = in_pos_w - CMP_W'(1);
    assign cnt_w      = CMP_W'(r_count);
    assign idx_w      = CMP_W'(r_idx);
    assign pos_a_w    = CMP_W'(r_pos_a);
    assign is_full    = (r_count == CNT_W'(CAPACITY));
    assign is_empty   = (r_count == '0);

    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.count = r_count;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos_a  = r_pos_a;
        n_val    = r_val;
        n_status = r_status;
        n_res    = r_res;
        o_ram    = '0;
        o_load   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val = i_in.value;
                    n_res = '0;
                    priority if (i_in.command == CMD_LIST) begin
                        if (is_empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_RESP;
                        end else begin
                            o_ram.rd_en   = 1'b1;
                            o_ram.rd_addr = '0;
                            n_idx         = '0;
                            n_state       = S_LIST;
                        end
                    end else if (i_in.command == CMD_INSERT) begin
                        priority if (is_full) begin
                            n_status = ST_FULL;
                            n_state  = S_RESP;
                        end else if (in_pos_w == '0 || in_pos_w > cnt_w + CMP_W'(1)) begin
                            n_status = ST_BADPOS;
                            n_state  = S_RESP;
                        end else if (pos_m1_w == cnt_w) begin
                            // append at the tail: no shift
                            n_pos_a = pos_m1_w[ADDR_W-1:0];
                            n_state = S_INS_WR;
                        end else begin
                            n_pos_a       = pos_m1_w[ADDR_W-1:0];
                            o_ram.rd_en   = 1'b1;
                            o_ram.rd_addr = ADDR_W'(cnt_w - CMP_W'(1));
                            n_idx         = ADDR_W'(cnt_w);
                            n_state       = S_INS_SHIFT;
                        end
                    end else if (i_in.command == CMD_DELETE) begin
                        priority if (is_empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_RESP;
                        end else if (in_pos_w == '0 || in_pos_w > cnt_w) begin
                            n_status = ST_BADPOS;
                            n_state  = S_RESP;
                        end else begin
                            n_pos_a       = pos_m1_w[ADDR_W-1:0];
                            o_ram.rd_en   = 1'b1;
                            o_ram.rd_addr = pos_m1_w[ADDR_W-1:0];
                            n_state       = S_DEL_RM;
                        end
                    end else begin
                        // undefined command: drop without a result
                        n_state = S_IDLE;
                    end
                end
            end

            S_LIST: begin
                if (i_out_free) begin
                    o_load.valid         = 1'b1;
                    o_load.res.status    = ST_OK;
                    o_load.res.value_res = i_rd_data;
                    o_load.res.count     = count_field(r_count);
                    o_load.res.last      = (idx_w + CMP_W'(1) == cnt_w);
                    if (idx_w + CMP_W'(1) == cnt_w) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ram.rd_en   = 1'b1;
                        o_ram.rd_addr = r_idx + ADDR_W'(1);
                        n_idx         = r_idx + ADDR_W'(1);
                    end
                end
            end

            S_INS_SHIFT: begin
                o_ram.wr_en   = 1'b1;
                o_ram.wr_addr = r_idx;
                o_ram.wr_data = i_rd_data;
                if (idx_w == pos_a_w + CMP_W'(1)) begin
                    n_state = S_INS_WR;
                end else begin
                    o_ram.rd_en   = 1'b1;
                    o_ram.rd_addr = r_idx - ADDR_W'(2);
                    n_idx         = r_idx - ADDR_W'(1);
                end
            end

            S_INS_WR: begin
                o_ram.wr_en   = 1'b1;
                o_ram.wr_addr = r_pos_a;
                o_ram.wr_data = r_val;
                n_count       = r_count + CNT_W'(1);
                n_status      = ST_OK;
                n_res         = r_val;
                n_state       = S_RESP;
            end

            S_DEL_RM: begin
                n_status = ST_OK;
                n_res    = i_rd_data;
                n_idx    = r_pos_a;
                if (pos_a_w + CMP_W'(1) == cnt_w) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_RESP;
                end else begin
                    o_ram.rd_en   = 1'b1;
                    o_ram.rd_addr = r_pos_a + ADDR_W'(1);
                    n_state       = S_DEL_SHIFT;
                end
            end

            S_DEL_SHIFT: begin
                o_ram.wr_en   = 1'b1;
                o_ram.wr_addr = r_idx;
                o_ram.wr_data = i_rd_data;
                if (idx_w + CMP_W'(2) == cnt_w) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_RESP;
                end else begin
                    o_ram.rd_en   = 1'b1;
                    o_ram.rd_addr = r_idx + ADDR_W'(2);
                    n_idx         = r_idx + ADDR_W'(1);
                end
            end

            S_RESP: begin
                if (i_out_free) begin
                    o_load.valid         = 1'b1;
                    o_load.res.status    = r_status;
                    o_load.res.value_res = r_res;
                    o_load.res.count     = count_field(r_count);
                    o_load.res.last      = 1'b1;
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_pos_a  <= n_pos_a;
        r_val    <= n_val;
        r_status <= n_status;
        r_res    <= n_res;
    end
endmodule

// ----- tb/pia_list_checker.sv -----
// ----------------------------------------------------------------------------
// pia_list_checker
// Watches the command and result channels of the positional list, keeps a
// shadow copy of the list, predicts every result and compares it field by
// field with what the block delivers.
// ----------------------------------------------------------------------------
module pia_list_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pia_in_if    cmd_ch,
    pia_out_if   res_ch,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pia_pkg::*;

    logic signed [VAL_W-1:0] shadow_entries [CAPACITY];
    int                      shadow_len;
    t_res                    awaited_results [$];
    int                      fail_total;

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        fail_total++;
        $display("ERROR %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    function automatic void queue_result(t_status st, logic signed [VAL_W-1:0] v,
                                         logic last);
        t_res r;
        r.status    = st;
        r.value_res = v;
        r.count     = COUNT_W'(shadow_len);
        r.last      = last;
        awaited_results.push_back(r);
    endfunction

    // Advance the shadow list by one accepted command and queue its results.
    function automatic void apply_list_command(logic [1:0] cmd, logic [POS_W-1:0] pos,
                                               logic signed [VAL_W-1:0] val);
        int p;
        int i;
        logic signed [VAL_W-1:0] removed;
        p = int'(pos);
        case (cmd)
            CMD_LIST: begin
                if (shadow_len == 0)
                    queue_result(ST_EMPTY, '0, 1'b1);
                for (i = 0; i < shadow_len; i++)
                    queue_result(ST_OK, shadow_entries[i], i + 1 == shadow_len);
            end
            CMD_INSERT: begin
                // Fullness wins over a bad position.
                if (shadow_len >= CAPACITY)
                    queue_result(ST_FULL, '0, 1'b1);
                else if (p < 1 || p > shadow_len + 1)
                    queue_result(ST_BADPOS, '0, 1'b1);
                else begin
                    for (i = shadow_len; i >= p; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[p-1] = val;
                    shadow_len++;
                    queue_result(ST_OK, val, 1'b1);
                end
            end
            CMD_DELETE: begin
                // Emptiness wins over a bad position; count reads zero then.
                if (shadow_len == 0)
                    queue_result(ST_EMPTY, '0, 1'b1);
                else if (p < 1 || p > shadow_len)
                    queue_result(ST_BADPOS, '0, 1'b1);
                else begin
                    removed = shadow_entries[p-1];
                    for (i = p - 1; i + 1 < shadow_len; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_len--;
                    queue_result(ST_OK, removed, 1'b1);
                end
            end
            default: ; // unused code: dropped, no result
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    flag_mismatch("result with none expected", res_ch.value_res, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (res_ch.status != want.status)
                        flag_mismatch("status", res_ch.status, want.status);
                    if (res_ch.value_res != want.value_res)
                        flag_mismatch("value_res", res_ch.value_res, want.value_res);
                    if (res_ch.count != want.count)
                        flag_mismatch("count", res_ch.count, want.count);
                    if (res_ch.last != want.last)
                        flag_mismatch("last", res_ch.last, want.last);
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
                apply_list_command(cmd_ch.command, cmd_ch.position, cmd_ch.value);
        end
        o_fail_count <= fail_total;
        o_pending    <= awaited_results.size();
    end

endmodule

// ----- tb/positional_array_insert_delete_tb.sv -----
// ----------------------------------------------------------------------------
// positional_array_insert_delete_tb
// Stimulus and verdict for the positional list. Drives a directed opening on
// the refusal cases and the list ends, fills the list to capacity, stalls the
// result side long enough to back the block up, then runs random command mixes
// and drains the list; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module positional_array_insert_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pia_pkg::*;

    // Command code 3 has no meaning; the block drops it silently.
    localparam t_cmd CMD_UNUSED  = 2'd3;
    localparam int   HOLD_CYCLES = 300;
    // Worst case for one item: a full list, one result per cycle plus overhead.
    localparam int   SETTLE_CYCLES = 2 * CAPACITY + 16;

    logic i_clk;
    logic i_rst_n;

    pia_in_if  cmd_ch ();
    pia_out_if res_ch ();

    int mismatch_total;
    int results_outstanding;

    // Stimulus-side view of the list length, used only to steer positions.
    int list_len;
    bit tx_gaps;
    bit rx_gaps;
    // Number of long hold-offs requested of the result side.
    int hold_off_reqs;

    positional_array_insert_delete dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    pia_list_checker list_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cmd_ch       (cmd_ch),
        .res_ch       (res_ch),
        .o_fail_count (mismatch_total),
        .o_pending    (results_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    // Offer one command item, with optional idle cycles ahead of it, and hold
    // it until the block takes it. Valid stays high into the next call so
    // back-to-back items need no extra assignment in the same step.
    task automatic send_item(t_cmd c, logic [POS_W-1:0] p, logic signed [VAL_W-1:0] v);
        while (tx_gaps && $urandom_range(99) < 10) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= c;
        cmd_ch.position <= p;
        cmd_ch.value    <= v;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (c == CMD_INSERT && list_len < CAPACITY && p >= 1 && p <= list_len + 1)
            list_len++;
        else if (c == CMD_DELETE && list_len > 0 && p >= 1 && p <= list_len)
            list_len--;
    endtask

    // Mostly a legal position in 1..upper; otherwise anything the field holds.
    function automatic logic [POS_W-1:0] pick_position(int upper);
        if (upper >= 1 && $urandom_range(99) < 85)
            return POS_W'($urandom_range(upper, 1));
        return POS_W'($urandom_range(127, 0));
    endfunction

    // One random command: insert and delete shares in percent, the rest lists,
    // with a small share of the unused code.
    task automatic send_random_item(int ins_pct, int del_pct);
        int r;
        r = $urandom_range(99);
        if (r < ins_pct)
            send_item(CMD_INSERT, pick_position(list_len + 1), $urandom);
        else if (r < ins_pct + del_pct)
            send_item(CMD_DELETE, pick_position(list_len), $urandom);
        else if (r < 97)
            send_item(CMD_LIST, pick_position(list_len), $urandom);
        else
            send_item(CMD_UNUSED, pick_position(list_len), $urandom);
    endtask

    // Result side: random stalls, plus one long hold-off on request so the
    // output register fills and the block stops taking commands.
    initial begin
        int holds_served;
        holds_served = 0;
        forever begin
            if (hold_off_reqs != holds_served) begin
                holds_served++;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                res_ch.ready <= !(rx_gaps && $urandom_range(99) < 10);
                @(posedge i_clk);
            end
        end
    end

    initial begin
        cmd_ch.valid    <= 1'b0;
        cmd_ch.command  <= CMD_LIST;
        cmd_ch.position <= '0;
        cmd_ch.value    <= '0;
        i_rst_n         <= 1'b0;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        hold_off_reqs = 0;
        list_len      = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: list, delete (also with position 0, emptiness first).
        send_item(CMD_LIST,   7'd1,   $urandom);
        send_item(CMD_DELETE, 7'd1,   $urandom);
        send_item(CMD_DELETE, 7'd0,   $urandom);
        // Insert outside 1..count+1 is refused.
        send_item(CMD_INSERT, 7'd0,   32'sh7FFF_FFFF);
        send_item(CMD_INSERT, 7'd2,   32'sh8000_0000);
        // Build a short list: first, append, front, middle, with value extremes.
        send_item(CMD_INSERT, 7'd1,   32'sh7FFF_FFFF);
        send_item(CMD_INSERT, 7'd2,   32'sh8000_0000);
        send_item(CMD_INSERT, 7'd1,   -32'sd1);
        send_item(CMD_INSERT, 7'd2,   32'sd0);
        // Unused code: dropped, no result.
        send_item(CMD_UNUSED, 7'd127, $urandom);
        send_item(CMD_LIST,   7'd0,   $urandom);
        // Delete outside 1..count, insert far out of range.
        send_item(CMD_DELETE, 7'd5,   $urandom);
        send_item(CMD_DELETE, 7'd127, $urandom);
        send_item(CMD_INSERT, 7'd127, $urandom);
        send_item(CMD_INSERT, 7'd6,   $urandom);
        // Remove last, first, middle, then list what is left.
        send_item(CMD_DELETE, 7'd4,   $urandom);
        send_item(CMD_DELETE, 7'd1,   $urandom);
        send_item(CMD_INSERT, 7'd2,   32'sh5555_AAAA);
        send_item(CMD_DELETE, 7'd2,   $urandom);
        send_item(CMD_LIST,   7'd3,   $urandom);

        // Fill to capacity at random legal positions.
        while (list_len < CAPACITY)
            send_item(CMD_INSERT, POS_W'($urandom_range(list_len + 1, 1)), $urandom);

        // Full list: fullness is checked before the position.
        send_item(CMD_INSERT, 7'd0,  $urandom);
        send_item(CMD_INSERT, 7'd65, $urandom);
        send_item(CMD_INSERT, 7'd1,  $urandom);

        // Stall the result side through a full listing while commands keep
        // coming, so the block backs up and drops its ready.
        hold_off_reqs++;
        send_item(CMD_LIST,   7'd0,  $urandom);
        send_item(CMD_INSERT, 7'd64, $urandom);
        send_item(CMD_DELETE, 7'd64, $urandom);
        send_item(CMD_DELETE, 7'd1,  $urandom);
        send_item(CMD_LIST,   7'd0,  $urandom);

        // Back-to-back stretch with no idling on either side.
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (15) send_random_item(45, 40);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        repeat (15) send_random_item(45, 40);

        // Drain to empty at random legal positions, then touch the empty
        // cases once more.
        while (list_len > 0)
            send_item(CMD_DELETE, POS_W'($urandom_range(list_len, 1)), $urandom);
        send_item(CMD_LIST,   7'd0, $urandom);
        send_item(CMD_DELETE, 7'd3, $urandom);
        cmd_ch.valid <= 1'b0;

        // Wait out every expected result, then let any dropped item settle.
        while (results_outstanding != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_total == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/pia_pkg.sv
sv/pia_in_if.sv
sv/pia_out_if.sv
sv/pia_ram.sv
sv/pia_out_reg.sv
sv/pia_ctrl.sv
sv/positional_array_insert_delete.sv
tb/pia_list_checker.sv
tb/positional_array_insert_delete_tb.sv
